[sv/fum_pkg.sv]
// Shared constants, register codes and a saturation helper for the fisheye undistortion mapper.
package fum_pkg;

    localparam int PIX_W        = 12;
    localparam int CRD_W        = 16;
    localparam int TIDX_W       = 10;
    localparam int TVAL_W       = 24;
    localparam int PS_W         = 24;
    localparam int TCNT_W       = 11;
    localparam int MAXA_W       = 10;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int FR_W         = 16;
    localparam int X0_W         = 24;
    localparam int RAD_W        = 40;
    localparam int OFF_W        = 18;
    localparam int SUM_W        = 20;
    localparam int CORDIC_STEPS = 20;
    localparam int ANG_W        = 25;
    localparam int Z_W          = 28;
    localparam int LO_W         = Z_W - 1 - FR_W;

    localparam logic [ANG_W-1:0] STEP_ANGLE [CORDIC_STEPS] = '{
        25'd29491200, 25'd17409672, 25'd9198793, 25'd4669451, 25'd2343786,
        25'd1173036, 25'd586661, 25'd293348, 25'd146676, 25'd73339,
        25'd36669, 25'd18335, 25'd9167, 25'd4584, 25'd2292,
        25'd1146, 25'd573, 25'd286, 25'd143, 25'd72
    };

    localparam logic signed [CRD_W-1:0] INVALID_COORD = -16'sd16;
    localparam logic signed [CRD_W-1:0] SAT_MAX       = 16'sh7fff;
    localparam logic signed [CRD_W-1:0] SAT_MIN       = -16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_CX    = 3'd0,
        REG_OUT_CY    = 3'd1,
        REG_FOCAL     = 3'd2,
        REG_SRC_CX    = 3'd3,
        REG_SRC_CY    = 3'd4,
        REG_PIX_SIZE  = 3'd5,
        REG_TBL_COUNT = 3'd6,
        REG_MAX_ANGLE = 3'd7
    } t_cfg_reg;

    function automatic logic signed [CRD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [CRD_W-1:0] res;
        if (v > SUM_W'(SAT_MAX)) begin
            res = SAT_MAX;
        end else if (v < SUM_W'(SAT_MIN)) begin
            res = SAT_MIN;
        end else begin
            res = CRD_W'(v);
        end
        return res;
    endfunction

endpackage

[sv/fum_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
module fum_sqrt #(
    parameter int V_W  = 49,
    parameter int Q_W  = 25,
    parameter int SB_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_vld,
    input  logic [V_W-1:0]  i_val,
    input  logic [SB_W-1:0] i_side,
    output logic            o_vld,
    output logic [Q_W-1:0]  o_root,
    output logic [SB_W-1:0] o_side
);
    localparam int PAD_W = 2 * Q_W;
    localparam int REM_W = Q_W + 3;

    logic             r_vld  [Q_W];
    logic [PAD_W-1:0] r_val  [Q_W];
    logic [REM_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_root [Q_W];
    logic [SB_W-1:0]  r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             p_vld;
        logic [PAD_W-1:0] p_val;
        logic [REM_W-1:0] p_rem;
        logic [Q_W-1:0]   p_root;
        logic [SB_W-1:0]  p_side;
        logic [REM_W-1:0] w_cat;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_val  = PAD_W'(i_val);
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_val  = r_val[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        assign w_cat   = {p_rem[REM_W-3:0], p_val[PAD_W-1-2*k -: 2]};
        assign w_trial = REM_W'({p_root, 2'b01});
        assign w_ge    = (w_cat >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_val[k]  <= p_val;
                r_rem[k]  <= w_ge ? (w_cat - w_trial) : w_cat;
                r_root[k] <= Q_W'({p_root, w_ge});
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_root = r_root[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

[sv/fum_cordic.sv]
// Pipelined CORDIC in vectoring mode that measures the off-axis angle.
module fum_cordic #(
    parameter int X_W  = 24,
    parameter int Y_W  = 25,
    parameter int W_C  = 28,
    parameter int SB_W = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  logic                             i_vld,
    input  logic [X_W-1:0]                   i_x0,
    input  logic [Y_W-1:0]                   i_y0,
    input  logic [SB_W-1:0]                  i_side,
    output logic                             o_vld,
    output logic signed [fum_pkg::Z_W-1:0]   o_z,
    output logic [SB_W-1:0]                  o_side
);
    import fum_pkg::*;

    logic                  r_vld  [CORDIC_STEPS];
    logic signed [W_C-1:0] r_x    [CORDIC_STEPS];
    logic signed [W_C-1:0] r_y    [CORDIC_STEPS];
    logic signed [Z_W-1:0] r_z    [CORDIC_STEPS];
    logic [SB_W-1:0]       r_side [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
        logic                  p_vld;
        logic signed [W_C-1:0] p_x;
        logic signed [W_C-1:0] p_y;
        logic signed [Z_W-1:0] p_z;
        logic [SB_W-1:0]       p_side;
        logic signed [W_C-1:0] w_xs;
        logic signed [W_C-1:0] w_ys;
        logic signed [Z_W-1:0] w_ang;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_x    = W_C'(i_x0);
            assign p_y    = W_C'(i_y0);
            assign p_z    = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_x    = r_x[k-1];
            assign p_y    = r_y[k-1];
            assign p_z    = r_z[k-1];
            assign p_side = r_side[k-1];
        end

        assign w_xs  = p_x[W_C-1] ? -((-p_x) >>> k) : (p_x >>> k);
        assign w_ys  = p_y[W_C-1] ? -((-p_y) >>> k) : (p_y >>> k);
        assign w_ang = Z_W'(STEP_ANGLE[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (!p_y[W_C-1]) begin
                    r_x[k] <= p_x + w_ys;
                    r_y[k] <= p_y - w_xs;
                    r_z[k] <= p_z + w_ang;
                end else begin
                    r_x[k] <= p_x - w_ys;
                    r_y[k] <= p_y + w_xs;
                    r_z[k] <= p_z - w_ang;
                end
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[CORDIC_STEPS-1];
    assign o_z    = r_z[CORDIC_STEPS-1];
    assign o_side = r_side[CORDIC_STEPS-1];

endmodule

[sv/fum_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow flag.
module fum_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 24,
    parameter int Q_W   = 40,
    parameter int SB_W  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_side,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf,
    output logic [SB_W-1:0]  o_side
);
    localparam int TOP_W = (NUM_W > Q_W) ? NUM_W - Q_W : 1;
    localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

    logic             r_vld  [Q_W+1];
    logic             r_ovf  [Q_W+1];
    logic [DEN_W-1:0] r_rem  [Q_W+1];
    logic [Q_W-1:0]   r_low  [Q_W+1];
    logic [Q_W-1:0]   r_quo  [Q_W+1];
    logic [DEN_W-1:0] r_den  [Q_W+1];
    logic [SB_W-1:0]  r_side [Q_W+1];

    logic             w_ovf0;
    logic [DEN_W-1:0] w_rem0;

    if (NUM_W > Q_W) begin : g_top
        logic [TOP_W-1:0] w_top;
        assign w_top  = i_num[NUM_W-1:Q_W];
        assign w_ovf0 = (CMP_W'(w_top) >= CMP_W'(i_den));
        assign w_rem0 = DEN_W'(w_top);
    end else begin : g_full
        assign w_ovf0 = 1'b0;
        assign w_rem0 = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ovf[0]  <= w_ovf0;
            r_rem[0]  <= w_rem0;
            r_low[0]  <= i_num[Q_W-1:0];
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        logic [DEN_W:0] w_cat;
        logic           w_ge;
        logic [DEN_W:0] w_diff;

        assign w_cat  = {r_rem[k-1], r_low[k-1][Q_W-k]};
        assign w_ge   = (w_cat >= {1'b0, r_den[k-1]});
        assign w_diff = w_cat - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_rem[k]  <= w_ge ? DEN_W'(w_diff) : DEN_W'(w_cat);
                r_low[k]  <= r_low[k-1];
                r_quo[k]  <= Q_W'({r_quo[k-1], w_ge});
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[Q_W];
    assign o_quo  = r_quo[Q_W];
    assign o_ovf  = r_ovf[Q_W];
    assign o_side = r_side[Q_W];

endmodule

[sv/fisheye_undistort_map_lut.sv]
// Top level of the fisheye undistortion mapper: table store and full pixel pipeline.
//
// Input channel (i_valid / o_stall): a request with i_command low writes i_table_value
// into table entry i_table_index and gives no result; a request with i_command high maps
// pixel (i_pixel_x, i_pixel_y) to a source coordinate.
// Output channel (o_valid / i_stall): one result per map request, in request order,
// carrying o_src_x, o_src_y (signed Q12.4, saturated) and o_valid_res.
// Configuration channel (i_cfg_valid / o_cfg_ready): always ready; write registers only
// while no request is in flight.
// Throughput is one request per clock while the receiver does not stall. At the default
// parameters a request passes from input to output through three front stages,
// 25 square root stages, 20 CORDIC stages, the address stage, the table read, the
// interpolation product, a 41 stage radius divider, two multiply and add stages, a 19 stage
// offset divider and the output register.
// A table write takes effect when it passes the table read stage, so later map requests
// see it. The table content is undefined after reset until written.
// Reset clears all pipeline valid bits and loads the configuration reset values.
// When the receiver stalls with a result held, the whole pipeline freezes and o_stall rises
// in the same cycle; nothing is dropped or repeated.
module fisheye_undistort_map_lut #(
    parameter int TABLE_DEPTH     = 1024,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_command,
    input  logic [fum_pkg::TIDX_W-1:0]           i_table_index,
    input  logic [fum_pkg::TVAL_W-1:0]           i_table_value,
    input  logic [fum_pkg::PIX_W-1:0]            i_pixel_x,
    input  logic [fum_pkg::PIX_W-1:0]            i_pixel_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [fum_pkg::CRD_W-1:0]     o_src_x,
    output logic signed [fum_pkg::CRD_W-1:0]     o_src_y,
    output logic                                 o_valid_res,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fum_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fum_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import fum_pkg::*;

    localparam int F      = COORD_FRAC_BITS;
    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int DX_W   = (((PIX_W + F) > CRD_W) ? (PIX_W + F) : CRD_W) + 1;
    localparam int SQ_W   = 2 * DX_W - 2;
    localparam int R2_W   = 2 * DX_W - 1;
    localparam int V_W    = R2_W + 16;
    localparam int RQ_W   = (V_W + 1) / 2;
    localparam int MAG_W  = DX_W - 1;
    localparam int DEN_W  = RQ_W + 8 - F;
    localparam int HALF_W = RAD_W / 2;
    localparam int P_W    = MAG_W + HALF_W;
    localparam int NUM_W  = MAG_W + RAD_W + 1;
    localparam int W_C    = ((RQ_W > X0_W) ? RQ_W : X0_W) + 3;

    typedef struct packed {
        logic                   cmd;
        logic [TIDX_W-1:0]      tidx;
        logic [TVAL_W-1:0]      tval;
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic                   zero;
    } t_front;

    typedef struct packed {
        t_front          front;
        logic [RQ_W-1:0] rq;
    } t_mid;

    typedef struct packed {
        logic                   ok;
        logic                   zero;
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic [RQ_W-1:0]        rq;
    } t_back;

    typedef struct packed {
        logic ok;
        logic zero;
        logic neg;
    } t_tail;

    // Configuration registers.
    logic [CRD_W-1:0]  r_out_cx;
    logic [CRD_W-1:0]  r_out_cy;
    logic [CRD_W-1:0]  r_focal;
    logic [CRD_W-1:0]  r_src_cx;
    logic [CRD_W-1:0]  r_src_cy;
    logic [PS_W-1:0]   r_pix_size;
    logic [TCNT_W-1:0] r_tbl_count;
    logic [MAXA_W-1:0] r_max_angle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cx    <= '0;
            r_out_cy    <= '0;
            r_focal     <= 16'd4096;
            r_src_cx    <= '0;
            r_src_cy    <= '0;
            r_pix_size  <= 24'd65536;
            r_tbl_count <= '0;
            r_max_angle <= 10'd1000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OUT_CX:    r_out_cx    <= CRD_W'(i_cfg_data);
                REG_OUT_CY:    r_out_cy    <= CRD_W'(i_cfg_data);
                REG_FOCAL:     r_focal     <= CRD_W'(i_cfg_data);
                REG_SRC_CX:    r_src_cx    <= CRD_W'(i_cfg_data);
                REG_SRC_CY:    r_src_cy    <= CRD_W'(i_cfg_data);
                REG_PIX_SIZE:  r_pix_size  <= PS_W'(i_cfg_data);
                REG_TBL_COUNT: r_tbl_count <= TCNT_W'(i_cfg_data);
                REG_MAX_ANGLE: r_max_angle <= MAXA_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline advance.
    logic r_out_vld;
    logic w_adv;

    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    // Stage 1: offsets from the corrected principal point.
    logic                   r_s1_vld;
    t_front                 r_s1_front;
    logic signed [DX_W-1:0] w_dx;
    logic signed [DX_W-1:0] w_dy;

    assign w_dx = (DX_W'(i_pixel_x) << F) - DX_W'(r_out_cx);
    assign w_dy = (DX_W'(i_pixel_y) << F) - DX_W'(r_out_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_front.cmd  <= i_command;
            r_s1_front.tidx <= i_table_index;
            r_s1_front.tval <= i_table_value;
            r_s1_front.dx   <= w_dx;
            r_s1_front.dy   <= w_dy;
            r_s1_front.zero <= 1'b0;
        end
    end

    // Stage 2: squares.
    logic                     r_s2_vld;
    t_front                   r_s2_front;
    logic [SQ_W-1:0]          r_s2_sqx;
    logic [SQ_W-1:0]          r_s2_sqy;
    logic signed [2*DX_W-1:0] w_sqx;
    logic signed [2*DX_W-1:0] w_sqy;

    assign w_sqx = r_s1_front.dx * r_s1_front.dx;
    assign w_sqy = r_s1_front.dy * r_s1_front.dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_front <= r_s1_front;
            r_s2_sqx   <= SQ_W'(w_sqx);
            r_s2_sqy   <= SQ_W'(w_sqy);
        end
    end

    // Stage 3: squared radius.
    logic            r_s3_vld;
    t_front          r_s3_front;
    t_front          n_s3_front;
    logic [R2_W-1:0] r_s3_r2;
    logic [R2_W-1:0] w_r2;

    assign w_r2 = R2_W'(r_s2_sqx) + R2_W'(r_s2_sqy);

    always_comb begin
        n_s3_front      = r_s2_front;
        n_s3_front.zero = (w_r2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_front <= n_s3_front;
            r_s3_r2    <= w_r2;
        end
    end

    // Radius in Q.(F+8).
    logic            w_sq_vld;
    logic [RQ_W-1:0] w_rq;
    t_front          w_sq_front;

    fum_sqrt #(
        .V_W  (V_W),
        .Q_W  (RQ_W),
        .SB_W ($bits(t_front))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s3_vld),
        .i_val   ({r_s3_r2, 16'd0}),
        .i_side  (r_s3_front),
        .o_vld   (w_sq_vld),
        .o_root  (w_rq),
        .o_side  (w_sq_front)
    );

    // Off-axis angle.
    t_mid                  w_co_in;
    logic                  w_co_vld;
    logic signed [Z_W-1:0] w_z;
    t_mid                  w_co_side;

    assign w_co_in.front = w_sq_front;
    assign w_co_in.rq    = w_rq;

    fum_cordic #(
        .X_W  (X0_W),
        .Y_W  (RQ_W),
        .W_C  (W_C),
        .SB_W ($bits(t_mid))
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_sq_vld),
        .i_x0    ({r_focal, 8'd0}),
        .i_y0    (w_rq),
        .i_side  (w_co_in),
        .o_vld   (w_co_vld),
        .o_z     (w_z),
        .o_side  (w_co_side)
    );

    // Stage 4: table addresses and range checks.
    logic              r_s4_vld;
    t_mid              r_s4_mid;
    logic [LO_W-1:0]   r_s4_lo;
    logic [LO_W:0]     r_s4_hi;
    logic [FR_W-1:0]   r_s4_fr;
    logic              r_s4_ok;
    logic [Z_W-2:0]    w_zu;
    logic [LO_W-1:0]   w_lo;
    logic [FR_W-1:0]   w_fr;
    logic [LO_W:0]     w_hi;
    logic [15:0]       w_count;
    logic              w_ok;

    assign w_zu    = (w_co_side.front.zero || w_z[Z_W-1]) ? '0 : w_z[Z_W-2:0];
    assign w_lo    = w_zu[Z_W-2:FR_W];
    assign w_fr    = w_zu[FR_W-1:0];
    assign w_hi    = {1'b0, w_lo} + (LO_W+1)'(w_fr != '0);
    assign w_count = (32'(r_tbl_count) < TABLE_DEPTH) ? 16'(r_tbl_count) : 16'(TABLE_DEPTH);
    assign w_ok    = (w_zu <= (Z_W-1)'({r_max_angle, 16'd0})) && (16'(w_hi) < w_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_adv) begin
            r_s4_vld <= w_co_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_mid <= w_co_side;
            r_s4_lo  <= w_lo;
            r_s4_hi  <= w_hi;
            r_s4_fr  <= w_fr;
            r_s4_ok  <= w_ok;
        end
    end

    // Stage 5: distortion table, written by load requests and read at floor and ceiling.
    logic [TVAL_W-1:0] r_tbl [TABLE_DEPTH];
    logic              r_s5_vld;
    t_back             r_s5_back;
    logic [FR_W-1:0]   r_s5_fr;
    logic [TVAL_W-1:0] r_s5_tl;
    logic [TVAL_W-1:0] r_s5_th;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s4_vld && !r_s4_mid.front.cmd
                && (32'(r_s4_mid.front.tidx) < TABLE_DEPTH)) begin
            r_tbl[AW'(r_s4_mid.front.tidx)] <= r_s4_mid.front.tval;
        end
        if (w_adv) begin
            r_s5_tl <= r_tbl[AW'(r_s4_lo)];
            r_s5_th <= r_tbl[AW'(r_s4_hi)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_adv) begin
            r_s5_vld <= r_s4_vld && r_s4_mid.front.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_back.ok   <= r_s4_ok;
            r_s5_back.zero <= r_s4_mid.front.zero;
            r_s5_back.dx   <= r_s4_mid.front.dx;
            r_s5_back.dy   <= r_s4_mid.front.dy;
            r_s5_back.rq   <= r_s4_mid.rq;
            r_s5_fr        <= r_s4_fr;
        end
    end

    // Stage 6: interpolation product.
    logic                          r_s6_vld;
    t_back                         r_s6_back;
    logic [TVAL_W-1:0]             r_s6_tl;
    logic signed [RAD_W+1:0]       r_s6_prod;
    logic signed [TVAL_W:0]        w_diff;
    logic signed [RAD_W+1:0]       w_prod;
    logic signed [RAD_W+1:0]       w_rad;

    assign w_diff = $signed({1'b0, r_s5_th}) - $signed({1'b0, r_s5_tl});
    assign w_prod = w_diff * $signed({1'b0, r_s5_fr});
    assign w_rad  = $signed({2'b00, r_s6_tl, 16'd0}) + r_s6_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (w_adv) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_back <= r_s5_back;
            r_s6_tl   <= r_s5_tl;
            r_s6_prod <= w_prod;
        end
    end

    // Radius in pixels, Q.16.
    logic [PS_W-1:0]  w_ps;
    logic             w_d1_vld;
    logic [RAD_W-1:0] w_rp;
    logic             w_d1_ovf;
    t_back            w_d1_back;

    assign w_ps = (r_pix_size == '0) ? PS_W'(1) : r_pix_size;

    fum_div #(
        .NUM_W (RAD_W),
        .DEN_W (PS_W),
        .Q_W   (RAD_W),
        .SB_W  ($bits(t_back))
    ) u_div_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s6_vld),
        .i_num   (w_rad[RAD_W-1:0]),
        .i_den   (w_ps),
        .i_side  (r_s6_back),
        .o_vld   (w_d1_vld),
        .o_quo   (w_rp),
        .o_ovf   (w_d1_ovf),
        .o_side  (w_d1_back)
    );

    // Stage 8: offset magnitude times radius, in two halves.
    logic             r_s8_vld;
    t_back            r_s8_back;
    logic [P_W-1:0]   r_s8_pxl;
    logic [P_W-1:0]   r_s8_pxh;
    logic [P_W-1:0]   r_s8_pyl;
    logic [P_W-1:0]   r_s8_pyh;
    logic [MAG_W-1:0] w_magx;
    logic [MAG_W-1:0] w_magy;

    assign w_magx = w_d1_back.dx[DX_W-1] ? MAG_W'(-w_d1_back.dx) : MAG_W'(w_d1_back.dx);
    assign w_magy = w_d1_back.dy[DX_W-1] ? MAG_W'(-w_d1_back.dy) : MAG_W'(w_d1_back.dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else if (w_adv) begin
            r_s8_vld <= w_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s8_back <= w_d1_back;
            r_s8_pxl  <= P_W'(w_magx) * P_W'(w_rp[HALF_W-1:0]);
            r_s8_pxh  <= P_W'(w_magx) * P_W'(w_rp[RAD_W-1:HALF_W]);
            r_s8_pyl  <= P_W'(w_magy) * P_W'(w_rp[HALF_W-1:0]);
            r_s8_pyh  <= P_W'(w_magy) * P_W'(w_rp[RAD_W-1:HALF_W]);
        end
    end

    // Stage 9: rounded numerators and the common denominator.
    logic             r_s9_vld;
    t_tail            r_s9_tail;
    logic             r_s9_negy;
    logic [NUM_W-1:0] r_s9_numx;
    logic [NUM_W-1:0] r_s9_numy;
    logic [DEN_W-1:0] r_s9_den;
    logic [DEN_W-1:0] w_den;

    assign w_den = DEN_W'(r_s8_back.rq) << (8 - F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_vld <= 1'b0;
        end else if (w_adv) begin
            r_s9_vld <= r_s8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s9_tail.ok   <= r_s8_back.ok;
            r_s9_tail.zero <= r_s8_back.zero;
            r_s9_tail.neg  <= r_s8_back.dx[DX_W-1];
            r_s9_negy      <= r_s8_back.dy[DX_W-1];
            r_s9_numx      <= (NUM_W'(r_s8_pxh) << HALF_W) + NUM_W'(r_s8_pxl)
                              + NUM_W'(w_den >> 1);
            r_s9_numy      <= (NUM_W'(r_s8_pyh) << HALF_W) + NUM_W'(r_s8_pyl)
                              + NUM_W'(w_den >> 1);
            r_s9_den       <= w_den;
        end
    end

    // Offsets along x and y.
    logic             w_dx_vld;
    logic [OFF_W-1:0] w_offx;
    logic             w_ovfx;
    t_tail            w_tail;
    logic             w_dy_vld;
    logic [OFF_W-1:0] w_offy;
    logic             w_ovfy;
    logic             w_negy;

    fum_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (OFF_W),
        .SB_W  ($bits(t_tail))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s9_vld),
        .i_num   (r_s9_numx),
        .i_den   (r_s9_den),
        .i_side  (r_s9_tail),
        .o_vld   (w_dx_vld),
        .o_quo   (w_offx),
        .o_ovf   (w_ovfx),
        .o_side  (w_tail)
    );

    fum_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (OFF_W),
        .SB_W  (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s9_vld),
        .i_num   (r_s9_numy),
        .i_den   (r_s9_den),
        .i_side  (r_s9_negy),
        .o_vld   (w_dy_vld),
        .o_quo   (w_offy),
        .o_ovf   (w_ovfy),
        .o_side  (w_negy)
    );

    // Output register.
    logic signed [CRD_W-1:0] r_out_x;
    logic signed [CRD_W-1:0] r_out_y;
    logic                    r_out_res;
    logic signed [SUM_W-1:0] w_sumx;
    logic signed [SUM_W-1:0] w_sumy;
    logic signed [CRD_W-1:0] w_cx_sat;
    logic signed [CRD_W-1:0] w_cy_sat;
    logic signed [CRD_W-1:0] n_out_x;
    logic signed [CRD_W-1:0] n_out_y;

    assign w_sumx   = w_tail.neg ? SUM_W'(r_src_cx) - SUM_W'(w_offx)
                                 : SUM_W'(r_src_cx) + SUM_W'(w_offx);
    assign w_sumy   = w_negy ? SUM_W'(r_src_cy) - SUM_W'(w_offy)
                             : SUM_W'(r_src_cy) + SUM_W'(w_offy);
    assign w_cx_sat = sat_coord(SUM_W'(r_src_cx));
    assign w_cy_sat = sat_coord(SUM_W'(r_src_cy));

    always_comb begin
        if (!w_tail.ok) begin
            n_out_x = INVALID_COORD;
            n_out_y = INVALID_COORD;
        end else if (w_tail.zero) begin
            n_out_x = w_cx_sat;
            n_out_y = w_cy_sat;
        end else begin
            if (w_ovfx) begin
                n_out_x = w_tail.neg ? SAT_MIN : SAT_MAX;
            end else begin
                n_out_x = sat_coord(w_sumx);
            end
            if (w_ovfy) begin
                n_out_y = w_negy ? SAT_MIN : SAT_MAX;
            end else begin
                n_out_y = sat_coord(w_sumy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x   <= n_out_x;
            r_out_y   <= n_out_y;
            r_out_res <= w_tail.ok;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_src_x     = r_out_x;
    assign o_src_y     = r_out_y;
    assign o_valid_res = r_out_res;

`ifndef SYNTHESIS
    a_invalid_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_src_x == INVALID_COORD && o_src_y == INVALID_COORD))
        else $error("invalid result without the invalid coordinate");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_vld == w_dy_vld)
        else $error("x and y offset dividers out of step");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("pipeline moves while a result is held");

    a_radius_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d1_vld |-> !w_d1_ovf)
        else $error("radius quotient overflow");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present right after reset");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for the fisheye undistortion mapper: table loads, map requests, checks.
`timescale 1ns / 1ps

module tb;
    import fum_pkg::*;

    typedef struct {
        logic signed [CRD_W-1:0] sx;
        logic signed [CRD_W-1:0] sy;
        logic                    ok;
    } t_map_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_command;
    logic [TIDX_W-1:0]     i_table_index;
    logic [TVAL_W-1:0]     i_table_value;
    logic [PIX_W-1:0]      i_pixel_x;
    logic [PIX_W-1:0]      i_pixel_y;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [CRD_W-1:0] o_src_x;
    logic signed [CRD_W-1:0] o_src_y;
    logic                  o_valid_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    localparam int DEPTH      = 1024;
    localparam int FILL_N     = 400;
    localparam int DRAIN_WAIT = 160;

    logic [TVAL_W-1:0] radius_lut [DEPTH];
    longint unsigned   reg_val [8];
    t_map_res          pending_maps [$];
    int                mismatches;
    int                hold_len;
    bit                quiet_rx;
    bit                quiet_tx;

    fisheye_undistort_map_lut dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("fisheye_undistort_map_lut verification failed");
        $finish;
    end

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint trunc_shift(input longint v, input int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint scale_offset(input longint d, input longint unsigned rp,
                                            input longint unsigned den,
                                            input longint unsigned ctr);
        longint unsigned mag;
        longint off;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        off = longint'((mag * rp + den / 2) / den);
        if (d < 0) off = -off;
        return clamp16(off + longint'(ctr));
    endfunction

    function automatic t_map_res map_pixel(input logic [PIX_W-1:0] px,
                                           input logic [PIX_W-1:0] py);
        t_map_res r;
        longint dx, dy, z, x, y, xs, ys, tl, th;
        longint unsigned r2, rq, lo, fr, hi, cnt, rad, rp, ps;
        bit ok;
        z = 0;
        dx = (longint'(px) << 4) - longint'(reg_val[REG_OUT_CX]);
        dy = (longint'(py) << 4) - longint'(reg_val[REG_OUT_CY]);
        r2 = longint'(dx * dx) + longint'(dy * dy);
        rq = root64(r2 << 16);
        if (r2 != 0) begin
            x = longint'(reg_val[REG_FOCAL]) << 8;
            y = longint'(rq);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = trunc_shift(x, i);
                ys = trunc_shift(y, i);
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(STEP_ANGLE[i]);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(STEP_ANGLE[i]);
                end
            end
            if (z < 0) z = 0;
        end
        lo = longint'(z) >> 16;
        fr = longint'(z) & 64'hFFFF;
        hi = lo + (fr != 0);
        cnt = (reg_val[REG_TBL_COUNT] < DEPTH) ? reg_val[REG_TBL_COUNT] : DEPTH;
        ok = 1'b1;
        if (longint'(z) > (reg_val[REG_MAX_ANGLE] << 16)) ok = 1'b0;
        if (hi >= cnt) ok = 1'b0;
        if (!ok) begin
            r.sx = INVALID_COORD;
            r.sy = INVALID_COORD;
        end else if (r2 == 0) begin
            r.sx = CRD_W'(clamp16(longint'(reg_val[REG_SRC_CX])));
            r.sy = CRD_W'(clamp16(longint'(reg_val[REG_SRC_CY])));
        end else begin
            tl = longint'(radius_lut[lo]);
            th = longint'(radius_lut[hi]);
            rad = longint'(tl * 65536 + (th - tl) * longint'(fr));
            ps = (reg_val[REG_PIX_SIZE] != 0) ? reg_val[REG_PIX_SIZE] : 1;
            rp = rad / ps;
            r.sx = CRD_W'(scale_offset(dx, rp, rq << 4, reg_val[REG_SRC_CX]));
            r.sy = CRD_W'(scale_offset(dy, rp, rq << 4, reg_val[REG_SRC_CY]));
        end
        r.ok = ok;
        return r;
    endfunction

    // Receiver side: random stalls, quiet stretches, and one long hold when asked.
    initial begin
        int len;
        logic v;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                v = 1'b1;
                len = hold_len;
                hold_len = 0;
            end else if (quiet_rx) begin
                v = 1'b0;
                len = 1;
            end else begin
                v = ($urandom_range(0, 2) == 0);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                  : $urandom_range(1, 4);
            end
            i_stall <= v;
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_map_res e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_maps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result x=%0d y=%0d v=%0b",
                                               o_src_x, o_src_y, o_valid_res);
            end else begin
                e = pending_maps.pop_front();
                if (o_src_x !== e.sx || o_src_y !== e.sy || o_valid_res !== e.ok) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d v=%0b, got x=%0d y=%0d v=%0b",
                                 e.sx, e.sy, e.ok, o_src_x, o_src_y, o_valid_res);
                end
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [TIDX_W-1:0] idx,
                                input logic [TVAL_W-1:0] val,
                                input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_table_index <= idx;
        i_table_value <= val;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (cmd == 1'b0) radius_lut[idx] = val;
        else pending_maps.insert(pending_maps.size(), map_pixel(px, py));
        gap = 0;
        if (!quiet_tx && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_map(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        send_request(1'b1, TIDX_W'($urandom), TVAL_W'($urandom), px, py);
    endtask

    task automatic send_load(input logic [TIDX_W-1:0] idx, input logic [TVAL_W-1:0] val);
        send_request(1'b0, idx, val, PIX_W'($urandom), PIX_W'($urandom));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input longint unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_PIX_SIZE:  reg_val[idx] = val & 64'hFFFFFF;
            REG_TBL_COUNT: reg_val[idx] = val & 64'h7FF;
            REG_MAX_ANGLE: reg_val[idx] = val & 64'h3FF;
            default:       reg_val[idx] = val & 64'hFFFF;
        endcase
    endtask

    task automatic write_all(input longint unsigned ocx, input longint unsigned ocy,
                             input longint unsigned f, input longint unsigned scx,
                             input longint unsigned scy, input longint unsigned ps,
                             input longint unsigned cnt, input longint unsigned amax);
        wait_idle();
        write_reg(REG_OUT_CX, ocx);
        write_reg(REG_OUT_CY, ocy);
        write_reg(REG_FOCAL, f);
        write_reg(REG_SRC_CX, scx);
        write_reg(REG_SRC_CY, scy);
        write_reg(REG_PIX_SIZE, ps);
        write_reg(REG_TBL_COUNT, cnt);
        write_reg(REG_MAX_ANGLE, amax);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_fill_table();
        for (int i = 0; i < FILL_N; i++)
            send_load(TIDX_W'(i), TVAL_W'(i * 12000 + $urandom_range(0, 999)));
        write_all(2048 << 4, 1536 << 4, 600 << 4, 1024 << 4, 1024 << 4, 65536, FILL_N, 1000);
    endtask

    task automatic test_directed();
        send_map(2048, 1536);
        send_map(0, 0);
        send_map(4095, 4095);
        send_map(0, 4095);
        send_map(4095, 0);
        send_map(2049, 1536);
        send_load(0, 24'h000000);
        send_load(1023, 24'hFFFFFF);
        send_load(0, 24'h001000);
        send_map(2048, 1536);
        write_all(0, 0, 4096, 65535, 65535, 1, 5, 1000);
        send_map(0, 0);
        send_map(3, 4);
        send_map(4095, 4095);
        write_all(1000, 1000, 0, 0, 0, 0, FILL_N, 0);
        send_map(0, 0);
        send_map(100, 3000);
        write_all(65535, 65535, 65535, 32768, 0, 16777215, 0, 1000);
        send_map(4095, 4095);
        send_map(0, 0);
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_load(TIDX_W'($urandom), TVAL_W'($urandom));
            else if ($urandom_range(0, 3) == 0)
                send_map(PIX_W'((reg_val[REG_OUT_CX] >> 4) + $urandom_range(0, 16) - 8),
                         PIX_W'((reg_val[REG_OUT_CY] >> 4) + $urandom_range(0, 16) - 8));
            else
                send_map(PIX_W'($urandom), PIX_W'($urandom));
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            quiet_rx = (p == 2);
            quiet_tx = (p == 2 || p == 4);
            if (p == 5)
                write_all(65535, 0, 1, 65535, 65535, 16777215, FILL_N, 1000);
            else
                write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(1, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(1, 200000),
                          $urandom_range(0, FILL_N), $urandom_range(0, 1000));
            random_burst(50);
        end
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
    endtask

    task automatic test_backpressure();
        write_all(2048 << 4, 2048 << 4, 3000 << 4, 1500 << 4, 1500 << 4, 40000, FILL_N, 900);
        quiet_tx = 1'b1;
        hold_len = 400;
        random_burst(180);
        quiet_tx = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        hold_len = 0;
        quiet_rx = 1'b0;
        quiet_tx = 1'b0;
        reg_val = '{0, 0, 4096, 0, 0, 65536, 0, 1000};
        foreach (radius_lut[i]) radius_lut[i] = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = 1'b0;
        i_table_index = '0;
        i_table_value = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_table();
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        if (pending_maps.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("fisheye_undistort_map_lut verification clean");
        end else begin
            $display("fisheye_undistort_map_lut verification failed");
        end
        $finish;
    end

endmodule
